// ===== sv/assert_macros.svh =====
// Assertion macros shared by the column statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CSU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("column statistics check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("column statistics sequence check failed");

`endif

// ===== sv/csu_pkg.sv =====
// Shared constants and types of the column statistics unit.
package csu_pkg;

	localparam int SUM_W = 64;

	typedef struct packed {
		logic start;
		logic ack;
	} div_cmd_t;

endpackage

// ===== sv/column_running_statistics_unit.sv =====
// Column running statistics unit: top level with stream ports and result register.
//
// Each input beat updates the counts, minimum, maximum and 64-bit wrapping sum
// registers. The mean (sum over non-null count, FRAC_BITS fraction bits, truncated
// toward zero and saturated) then comes from a radix-2 divider that retires one
// quotient bit per cycle. The divider goes straight to its done state while no
// non-null value has been seen, and skips the quotient bit steps when the quotient
// would overflow the mean width. s_tready stays low while the divider works. The
// finished result waits in an output register, so the next beat may be taken
// before it is read; a result still unread when the next one finishes holds the
// divider and s_tready until m_tready takes it.
// While the freeze register is set, beats leave the statistics unchanged but still
// produce a result.
`include "assert_macros.svh"

module column_running_statistics_unit import csu_pkg::*; #(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32,
	parameter int FRAC_BITS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// value, zero padding to whole bytes
	input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// is_null
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// minimum, maximum, total_sum, mean_value, non_null_count, item_count, zero padding
	output logic [((2*DATA_WIDTH + 64 + (((DATA_WIDTH+FRAC_BITS) > 64) ? 64 :
		(DATA_WIDTH+FRAC_BITS)) + 2*COUNT_WIDTH + 7)/8)*8-1:0] m_tdata,
	// all_null
	output logic                m_tuser
);

	localparam int MEAN_W = ((DATA_WIDTH + FRAC_BITS) > 64) ? 64 : (DATA_WIDTH + FRAC_BITS);
	localparam int OUT_W  = 2*DATA_WIDTH + SUM_W + MEAN_W + 2*COUNT_WIDTH;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	logic                   accept;
	logic                   busy_q;
	logic                   start_q;
	logic                   m_valid_q;
	logic [OUT_TW-1:0]      m_data_q;
	logic                   m_user_q;
	div_cmd_t               cmd;
	logic                   div_done;
	logic [MEAN_W-1:0]      mean;
	logic [DATA_WIDTH-1:0]  minimum;
	logic [DATA_WIDTH-1:0]  maximum;
	logic [SUM_W-1:0]       total_sum;
	logic [COUNT_WIDTH-1:0] non_null_count;
	logic [COUNT_WIDTH-1:0] item_count;

	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign cmd.start = start_q;
	assign cmd.ack   = div_done && (!m_valid_q || m_tready);

	csu_accum #(
		.DATA_WIDTH (DATA_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.upd           (accept),
		.value         (s_tdata[DATA_WIDTH-1:0]),
		.is_null       (s_tuser),
		.minimum       (minimum),
		.maximum       (maximum),
		.total_sum     (total_sum),
		.non_null_count(non_null_count),
		.item_count    (item_count)
	);

	csu_div #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.MEAN_W     (MEAN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sum   (total_sum),
		.cnt   (non_null_count),
		.done  (div_done),
		.mean  (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			start_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (cmd.ack) begin
				busy_q <= 1'b0;
			end
			if (cmd.ack) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) begin
			m_data_q <= OUT_TW'({item_count, non_null_count, mean, total_sum, maximum, minimum});
			m_user_q <= (non_null_count == '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`CSU_ASSERT(a_result_after_work, clk, arst_n, !$rose(m_tvalid) || $past(busy_q))

endmodule

// ===== sv/csu_accum.sv =====
// Running count, minimum, maximum and sum registers with the freeze register.
`include "assert_macros.svh"

module csu_accum import csu_pkg::*; #(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   upd,
	input  logic [DATA_WIDTH-1:0]  value,
	input  logic                   is_null,
	output logic [DATA_WIDTH-1:0]  minimum,
	output logic [DATA_WIDTH-1:0]  maximum,
	output logic [SUM_W-1:0]       total_sum,
	output logic [COUNT_WIDTH-1:0] non_null_count,
	output logic [COUNT_WIDTH-1:0] item_count
);

	logic                   frozen_q;
	logic [COUNT_WIDTH-1:0] items_q;
	logic [COUNT_WIDTH-1:0] values_q;
	logic [DATA_WIDTH-1:0]  min_q;
	logic [DATA_WIDTH-1:0]  max_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   take;
	logic                   take_val;

	assign take     = upd && !frozen_q;
	assign take_val = take && !is_null;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frozen_q <= 1'b0;
		end else if (cfg_we) begin
			frozen_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q  <= '0;
			values_q <= '0;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (take && !(&items_q)) begin
				items_q <= items_q + 1'b1;
			end
			if (take_val) begin
				if (!(&values_q)) begin
					values_q <= values_q + 1'b1;
				end
				sum_q <= sum_q + SUM_W'($signed(value));
				if (values_q == '0) begin
					min_q <= value;
					max_q <= value;
				end else begin
					if ($signed(value) < $signed(min_q)) begin
						min_q <= value;
					end
					if ($signed(value) > $signed(max_q)) begin
						max_q <= value;
					end
				end
			end
		end
	end

	assign minimum        = min_q;
	assign maximum        = max_q;
	assign total_sum      = sum_q;
	assign non_null_count = values_q;
	assign item_count     = items_q;

	`CSU_ASSERT(a_values_le_items, clk, arst_n, values_q <= items_q)

endmodule

// ===== sv/csu_div.sv =====
// Sequenced radix-2 restoring divider that forms the saturated fixed-point mean.
`include "assert_macros.svh"

module csu_div import csu_pkg::*; #(
	parameter int COUNT_WIDTH = 32,
	parameter int FRAC_BITS   = 8,
	parameter int MEAN_W      = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_cmd_t               cmd,
	input  logic [SUM_W-1:0]       sum,
	input  logic [COUNT_WIDTH-1:0] cnt,
	output logic                   done,
	output logic [MEAN_W-1:0]      mean
);

	localparam int DVW    = SUM_W + FRAC_BITS + 1;
	localparam int QW     = MEAN_W;
	localparam int HW     = DVW - QW;
	localparam int CMP_W  = (HW > COUNT_WIDTH) ? HW : COUNT_WIDTH;
	localparam int STEP_W = $clog2(QW);

	typedef enum logic [4:0] {
		D_IDLE  = 5'b00001,
		D_CHECK = 5'b00010,
		D_RUN   = 5'b00100,
		D_FIX   = 5'b01000,
		D_DONE  = 5'b10000
	} div_state_t;

	div_state_t             state_q;
	logic                   neg_q;
	logic [SUM_W-1:0]       mag_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [QW-1:0]          lo_q;
	logic [STEP_W-1:0]      step_q;

	logic [DVW-1:0]         dividend;
	logic [HW-1:0]          hi;
	logic                   ovf;
	logic [QW-1:0]          lim;
	logic [COUNT_WIDTH:0]   shifted;
	logic                   ge;

	assign dividend = DVW'(mag_q) << FRAC_BITS;
	assign hi       = dividend[DVW-1:QW];
	assign ovf      = CMP_W'(hi) >= CMP_W'(cnt_q);
	assign lim      = neg_q ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - 1'b1);
	assign shifted  = {rem_q, lo_q[QW-1]};
	assign ge       = shifted >= {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (cmd.start) begin
						state_q <= (cnt == '0) ? D_DONE : D_CHECK;
					end
				end
				D_CHECK: begin
					state_q <= ovf ? D_FIX : D_RUN;
					step_q  <= STEP_W'(QW - 1);
				end
				D_RUN: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					state_q <= D_DONE;
				end
				D_DONE: begin
					if (cmd.ack) begin
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (cmd.start) begin
					neg_q <= (cnt != '0) && sum[SUM_W-1];
					mag_q <= sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
					cnt_q <= cnt;
					lo_q  <= '0;
				end
			end
			D_CHECK: begin
				rem_q <= COUNT_WIDTH'(hi);
				lo_q  <= ovf ? lim : dividend[QW-1:0];
			end
			D_RUN: begin
				rem_q <= ge ? COUNT_WIDTH'(shifted - {1'b0, cnt_q}) : shifted[COUNT_WIDTH-1:0];
				lo_q  <= {lo_q[QW-2:0], ge};
			end
			D_FIX: begin
				if (lo_q > lim) begin
					lo_q <= lim;
				end
			end
			D_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == D_DONE);
	assign mean = neg_q ? (QW'(0) - lo_q) : lo_q;

	`CSU_ASSERT_NEXT(a_start_when_idle, clk, arst_n, cmd.start, $past(state_q) == D_IDLE)
	`CSU_ASSERT(a_ack_when_done, clk, arst_n, !cmd.ack || state_q == D_DONE)

endmodule

// ===== tb/column_running_statistics_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the column statistics unit: predicts each result beat and compares it.
module column_running_statistics_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// value
	input  logic [31:0]  s_tdata,
	// is_null
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// minimum, maximum, total_sum, mean_value, non_null_count, item_count
	input  logic [231:0] m_tdata,
	// all_null
	input  logic         m_tuser,
	output int           fail_count,
	output int           outstanding
);

	localparam int FRAC_W = 8;
	localparam int MEAN_W = 40;

	typedef struct packed {
		logic [31:0] minimum;
		logic [31:0] maximum;
		logic [63:0] total_sum;
		logic [39:0] mean_value;
		logic [31:0] non_null_count;
		logic [31:0] item_count;
		logic        all_null;
	} col_stats_t;

	logic        stats_frozen;
	logic [31:0] items_seen;
	logic [31:0] values_seen;
	logic [31:0] least_value;
	logic [31:0] greatest_value;
	logic [63:0] value_sum;
	col_stats_t  pending_stats[$];
	int          errs = 0;

	assign fail_count = errs;

	function automatic logic [MEAN_W-1:0] fixed_mean(input logic [63:0] sum, input logic [31:0] cnt);
		logic        neg;
		logic [63:0] mag, q, r, lim, m, div;
		if (cnt == 0)
			return '0;
		div = {32'd0, cnt};
		neg = sum[63];
		mag = neg ? -sum : sum;
		q = mag / div;
		r = mag % div;
		lim = (64'd1 << (MEAN_W - 1)) - 64'd1;
		if (neg)
			lim = lim + 64'd1;
		if (q > (lim >> FRAC_W)) begin
			m = lim;
		end else begin
			m = (q << FRAC_W) + ((r << FRAC_W) / div);
			if (m > lim)
				m = lim;
		end
		if (neg)
			m = -m;
		return m[MEAN_W-1:0];
	endfunction

	function automatic col_stats_t fold_beat(input logic [31:0] v, input logic nul);
		col_stats_t res;
		if (!stats_frozen) begin
			if (items_seen != '1)
				items_seen = items_seen + 1;
			if (!nul) begin
				if (values_seen == 0) begin
					least_value = v;
					greatest_value = v;
				end else begin
					if ($signed(v) < $signed(least_value))
						least_value = v;
					if ($signed(v) > $signed(greatest_value))
						greatest_value = v;
				end
				if (values_seen != '1)
					values_seen = values_seen + 1;
				value_sum = value_sum + {{32{v[31]}}, v};
			end
		end
		res.minimum        = least_value;
		res.maximum        = greatest_value;
		res.total_sum      = value_sum;
		res.mean_value     = fixed_mean(value_sum, values_seen);
		res.non_null_count = values_seen;
		res.item_count     = items_seen;
		res.all_null       = (values_seen == 0);
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		col_stats_t want;
		if (!arst_n) begin
			stats_frozen   = 1'b0;
			items_seen     = '0;
			values_seen    = '0;
			least_value    = '0;
			greatest_value = '0;
			value_sum      = '0;
			pending_stats.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_stats.size() == 0) begin
					$error("result beat with no expectation waiting");
					errs++;
				end else begin
					want = pending_stats.pop_front();
					compare_field("minimum", 64'(want.minimum), 64'(m_tdata[31:0]));
					compare_field("maximum", 64'(want.maximum), 64'(m_tdata[63:32]));
					compare_field("total_sum", want.total_sum, m_tdata[127:64]);
					compare_field("mean_value", 64'(want.mean_value), 64'(m_tdata[167:128]));
					compare_field("non_null_count", 64'(want.non_null_count),
						64'(m_tdata[199:168]));
					compare_field("item_count", 64'(want.item_count), 64'(m_tdata[231:200]));
					compare_field("all_null", 64'(want.all_null), 64'(m_tuser));
				end
			end
			if (cfg_we)
				stats_frozen = cfg_wdata;
			if (s_tvalid && s_tready)
				pending_stats.push_back(fold_beat(s_tdata, s_tuser));
			outstanding <= pending_stats.size();
		end
	end

endmodule

// ===== tb/tb_column_running_statistics_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the column statistics unit: stimulus, back-pressure and verdict.
module tb_column_running_statistics_unit;

	localparam int RES_W       = 232;
	localparam int ITEM_TARGET = 650;
	localparam int IDLE_LIMIT  = 2000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_wdata = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic [31:0]       s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tready  = 1'b0;
	logic              s_tready;
	logic              m_tvalid;
	logic [RES_W-1:0]  m_tdata;
	logic              m_tuser;
	int                fail_count;
	int                outstanding;
	bit                calm = 1'b0;
	int                stall_left = 0;
	int                idle_cycles = 0;
	int                beats_sent = 0;

	column_running_statistics_unit #(
		.DATA_WIDTH (32),
		.COUNT_WIDTH(32),
		.FRAC_BITS  (8)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	column_running_statistics_checker stats_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int stall_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 50);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] column_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2: return 32'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 9) < 3) begin
			stall_left = stall_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(input logic [31:0] v, input logic nul);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : stall_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= nul;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
	endtask

	// drop valid and hold until every result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_frozen(input logic val);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int run_len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// frozen before anything has been counted
		write_frozen(1'b1);
		send_beat(32'h7fff_ffff, 1'b1);
		send_beat(32'h8000_0000, 1'b0);
		write_frozen(1'b0);

		// nulls ahead of the first value, then the extremes
		send_beat(32'h7fff_ffff, 1'b1);
		send_beat(32'h8000_0000, 1'b1);
		send_beat(32'd5, 1'b0);
		send_beat(32'hffff_ffff, 1'b0);
		send_beat(32'h8000_0000, 1'b0);
		send_beat(32'h7fff_ffff, 1'b0);
		send_beat(32'd0, 1'b0);
		send_beat(32'hffff_ffff, 1'b1);
		send_beat(32'd3, 1'b0);

		write_frozen(1'b1);
		send_beat(32'h8000_0000, 1'b0);
		send_beat(32'd1, 1'b1);
		write_frozen(1'b0);

		while (beats_sent < ITEM_TARGET) begin
			run_len = $urandom_range(20, 120);
			if (run_len > ITEM_TARGET - beats_sent)
				run_len = ITEM_TARGET - beats_sent;
			write_frozen($urandom_range(0, 3) == 0);
			calm = ($urandom_range(0, 4) == 0);
			repeat (run_len)
				send_beat(column_value(), $urandom_range(0, 4) == 0);
			calm = 1'b0;
		end

		settle();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
